[rtl/kvma_pkg.sv]
// Shared constants, types and codes for the keyframe vertex morph animator.
// Used by the top level, kvma_lerp and kvma_checker; depends on nothing else.
package kvma_pkg;

    localparam int MAX_FRAMES = 64;
    localparam int MAX_VERTS  = 256;
    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;

    localparam int FRAME_W  = $clog2(MAX_FRAMES);
    localparam int VERT_W   = $clog2(MAX_VERTS);
    localparam int ADDR_W   = FRAME_W + VERT_W;
    localparam int DEPTH    = MAX_FRAMES * MAX_VERTS;
    localparam int VTX_W    = 3 * COORD_BITS;

    // Field widths of the stream items.
    localparam int KIND_W   = 2;
    localparam int FIDX_W   = 6;
    localparam int VIDX_W   = 8;
    localparam int POS_W    = 15;
    localparam int FPOS_W   = 14;
    localparam int CNT_W    = 4;

    localparam int IN_W         = FIDX_W + VIDX_W + VTX_W;
    localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W        = FPOS_W + 1 + VTX_W;
    localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_FRAMES   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANIM_END     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_STEP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIVIDER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE    = 3'd6;

    // Highest position the block can ever report: the last frame, no fraction.
    localparam logic [FPOS_W-1:0] POS_LIMIT = FPOS_W'((MAX_FRAMES - 1) << FRAC_BITS);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_READ    = 2'd2,
        KIND_RESTART = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDA,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    localparam logic [1:0] LANE_X = 2'd0;
    localparam logic [1:0] LANE_Y = 2'd1;
    localparam logic [1:0] LANE_Z = 2'd2;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] lane;
    } t_lerp_ctl;

endpackage

[rtl/keyframe_vertex_morph_animator.sv]
// Top level of the keyframe vertex morph animator: sequencer, animation state,
// configuration registers and output register. Uses kvma_pkg, kvma_ram and kvma_lerp.
//
// Usage: one result comes out for every input item. The block takes one item at a
// time under a small sequencer; load, tick and restart items, and reads of a vertex
// out of range, pass the execute and done states while the output register is free,
// and a read of a vertex in use also passes the second read state and the multiply and
// add states for each lane, set by two reads of the single read port of the vertex
// memory and three passes (multiply, then round and add) through the one shared
// interpolation multiplier. A finished result waits in an output register, so the next
// item is accepted while it is still pending. The vertex memory is not cleared: reading
// a vertex that was never loaded returns whatever the memory holds. Configuration
// writes are always accepted and must only be made while no item is in flight.
module keyframe_vertex_morph_animator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream. tdata, low bit first: frame_index, vertex_index, in_x, in_y, in_z.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [kvma_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: kind.
    input  logic [kvma_pkg::KIND_W-1:0]          s_axis_tuser,
    // Result stream. tdata, low bit first: frame_position, complete, out_x, out_y, out_z.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [kvma_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // Configuration write channel.
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [kvma_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kvma_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import kvma_pkg::*;

    // Configuration.
    logic [6:0]       r_num_frames;
    logic [8:0]       r_vert_count;
    logic [5:0]       r_anim_start;
    logic [5:0]       r_anim_end;
    logic [8:0]       r_frame_step;
    logic [CNT_W-1:0] r_tick_div;
    logic             r_loop_mode;

    // Animation state.
    logic [POS_W-1:0] r_pos;
    logic [CNT_W-1:0] r_tick_cnt;
    logic             r_done;

    // Latched item.
    t_kind              r_kind;
    logic [FIDX_W-1:0]  r_fidx;
    logic [VIDX_W-1:0]  r_vidx;
    logic [VTX_W-1:0]   r_vtx;

    t_state r_state;
    t_state n_state;
    logic [1:0] r_lane;

    logic [COORD_BITS-1:0] r_res_x;
    logic [COORD_BITS-1:0] r_res_y;
    logic [COORD_BITS-1:0] r_res_z;
    logic [VTX_W-1:0]      r_a_word;

    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;

    // Sequencer outputs.
    logic              in_take;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    t_lerp_ctl         lerp_ctl;
    logic              out_load;

    logic [VTX_W-1:0]      ram_rdata;
    logic [COORD_BITS-1:0] lerp_val;

    // Item decode.
    logic load_ok;
    logic read_ok;

    // Frame clamp and addresses.
    logic [7:0]        lim;
    logic [7:0]        whole0;
    logic [7:0]        whole1;
    logic [7:0]        f0;
    logic [7:0]        f1;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] waddr;

    // Tick arithmetic.
    logic [CNT_W-1:0] cnt_inc;
    logic [POS_W-1:0] pos_add;
    logic [POS_W-1:0] pos_start;
    logic [POS_W-1:0] pos_end;

    assign in_take     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        load_ok = ({3'b000, r_fidx} < 9'(MAX_FRAMES)) && ({1'b0, r_vidx} < 9'(MAX_VERTS));
        read_ok = ({1'b0, r_vidx} < r_vert_count) && ({1'b0, r_vidx} < 9'(MAX_VERTS));

        lim = (r_num_frames == 7'd0) ? 8'd0 : {1'b0, r_num_frames} - 8'd1;
        if (lim > 8'(MAX_FRAMES - 1)) begin
            lim = 8'(MAX_FRAMES - 1);
        end
        whole0 = 8'(r_pos[POS_W-1:FRAC_BITS]);
        whole1 = whole0 + 8'd1;
        f0 = (whole0 > lim) ? lim : whole0;
        f1 = (whole1 > lim) ? lim : whole1;
        addr0 = {f0[FRAME_W-1:0], r_vidx[VERT_W-1:0]};
        addr1 = {f1[FRAME_W-1:0], r_vidx[VERT_W-1:0]};
        waddr = {r_fidx[FRAME_W-1:0], r_vidx[VERT_W-1:0]};

        cnt_inc   = r_tick_cnt + CNT_W'(1);
        pos_add   = r_pos + POS_W'(r_frame_step);
        pos_start = POS_W'({r_anim_start, {FRAC_BITS{1'b0}}});
        pos_end   = POS_W'({r_anim_end, {FRAC_BITS{1'b0}}});
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = (r_kind == KIND_READ && read_ok) ? ST_RDA : ST_DONE;
            end
            ST_RDA: n_state = ST_MUL;
            ST_MUL: n_state = ST_ADD;
            ST_ADD: n_state = (r_lane == LANE_Z) ? ST_DONE : ST_MUL;
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_axis_tready   = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = addr0;
        lerp_ctl.mul_en = 1'b0;
        lerp_ctl.lane   = r_lane;
        out_load        = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EXEC: begin
                ram_we = (r_kind == KIND_LOAD) && load_ok;
                ram_re = (r_kind == KIND_READ) && read_ok;
            end
            ST_RDA: begin
                ram_re    = 1'b1;
                ram_raddr = addr1;
            end
            ST_MUL: lerp_ctl.mul_en = 1'b1;
            ST_ADD: ;
            ST_DONE: out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_lane       <= LANE_X;
            r_out_valid  <= 1'b0;
            r_pos        <= '0;
            r_tick_cnt   <= '0;
            r_done       <= 1'b0;
            r_num_frames <= 7'd1;
            r_vert_count <= 9'd1;
            r_anim_start <= 6'd0;
            r_anim_end   <= 6'd0;
            r_frame_step <= 9'd128;
            r_tick_div   <= 4'd1;
            r_loop_mode  <= 1'b1;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_NUM_FRAMES:   r_num_frames <= i_cfg_data[6:0];
                    CFG_VERT_COUNT:   r_vert_count <= i_cfg_data[8:0];
                    CFG_ANIM_START:   r_anim_start <= i_cfg_data[5:0];
                    CFG_ANIM_END:     r_anim_end   <= i_cfg_data[5:0];
                    CFG_FRAME_STEP:   r_frame_step <= i_cfg_data[8:0];
                    CFG_TICK_DIVIDER: r_tick_div   <= i_cfg_data[CNT_W-1:0];
                    CFG_LOOP_MODE:    r_loop_mode  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_state == ST_EXEC) begin
                r_lane <= LANE_X;
                if (r_kind == KIND_TICK) begin
                    if (cnt_inc >= r_tick_div) begin
                        r_tick_cnt <= '0;
                        // Passing the last frame either wraps or parks the animation.
                        if (pos_add > pos_end) begin
                            if (r_loop_mode) begin
                                r_pos <= pos_start;
                            end else begin
                                r_pos  <= pos_end;
                                r_done <= 1'b1;
                            end
                        end else begin
                            r_pos <= pos_add;
                        end
                    end else begin
                        r_tick_cnt <= cnt_inc;
                    end
                end else if (r_kind == KIND_RESTART) begin
                    r_pos      <= pos_start;
                    r_tick_cnt <= '0;
                    r_done     <= 1'b0;
                end
            end else if (r_state == ST_ADD && r_lane != LANE_Z) begin
                r_lane <= r_lane + 2'd1;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_fidx <= s_axis_tdata[FIDX_W-1:0];
            r_vidx <= s_axis_tdata[FIDX_W+VIDX_W-1:FIDX_W];
            r_vtx  <= s_axis_tdata[IN_W-1:FIDX_W+VIDX_W];
        end
        if (r_state == ST_EXEC) begin
            r_res_x <= '0;
            r_res_y <= '0;
            r_res_z <= '0;
        end
        if (r_state == ST_RDA) begin
            r_a_word <= ram_rdata;
        end
        if (r_state == ST_ADD) begin
            unique case (r_lane)
                LANE_X:  r_res_x <= lerp_val;
                LANE_Y:  r_res_y <= lerp_val;
                LANE_Z:  r_res_z <= lerp_val;
                default: ;
            endcase
        end
        if (out_load) begin
            r_out_data <= {r_res_z, r_res_y, r_res_x, r_done, r_pos[FPOS_W-1:0]};
        end
    end

    kvma_ram #(
        .WIDTH (VTX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (r_vtx),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The second frame's word stays on the memory output through all three lanes.
    kvma_lerp u_lerp (
        .i_clk    (i_clk),
        .i_ctl    (lerp_ctl),
        .i_a_word (r_a_word),
        .i_b_word (ram_rdata),
        .i_t      (r_pos[FRAC_BITS-1:0]),
        .o_val    (lerp_val)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_data);

endmodule

[rtl/kvma_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module kvma_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/kvma_lerp.sv]
// Shared interpolation unit: one signed multiply per lane, registered, then round and add.
// Depends on kvma_pkg for widths and lane codes.
module kvma_lerp (
    input  logic                               i_clk,
    input  kvma_pkg::t_lerp_ctl                i_ctl,
    input  logic [kvma_pkg::VTX_W-1:0]         i_a_word,
    input  logic [kvma_pkg::VTX_W-1:0]         i_b_word,
    input  logic [kvma_pkg::FRAC_BITS-1:0]     i_t,
    output logic [kvma_pkg::COORD_BITS-1:0]    o_val
);
    import kvma_pkg::*;

    localparam int PROD_W = COORD_BITS + FRAC_BITS + 2;

    logic [COORD_BITS-1:0]        a_sel;
    logic [COORD_BITS-1:0]        b_sel;
    logic signed [COORD_BITS:0]   diff;
    logic signed [PROD_W-1:0]     r_prod;
    logic [COORD_BITS-1:0]        r_a;
    logic signed [PROD_W-1:0]     a_ext;
    logic signed [PROD_W-1:0]     rnd;
    logic signed [PROD_W-1:0]     sum;

    always_comb begin
        unique case (i_ctl.lane)
            LANE_X: begin
                a_sel = i_a_word[COORD_BITS-1:0];
                b_sel = i_b_word[COORD_BITS-1:0];
            end
            LANE_Y: begin
                a_sel = i_a_word[2*COORD_BITS-1:COORD_BITS];
                b_sel = i_b_word[2*COORD_BITS-1:COORD_BITS];
            end
            LANE_Z: begin
                a_sel = i_a_word[3*COORD_BITS-1:2*COORD_BITS];
                b_sel = i_b_word[3*COORD_BITS-1:2*COORD_BITS];
            end
            default: begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
        diff = $signed({b_sel[COORD_BITS-1], b_sel}) - $signed({a_sel[COORD_BITS-1], a_sel});
    end

    // With no fraction the second frame plays no part, so its word is ignored.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_a    <= a_sel;
            r_prod <= (i_t == '0) ? '0 : PROD_W'(diff * $signed({1'b0, i_t}));
        end
    end

    // (256-t)*a + t*b equals 256*a + t*(b-a), so the result is a plus the
    // rounded, floored product; it always lies between a and b.
    always_comb begin
        a_ext = {{(PROD_W-COORD_BITS){r_a[COORD_BITS-1]}}, r_a};
        rnd   = (r_prod + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        sum   = a_ext + rnd;
        o_val = sum[COORD_BITS-1:0];
    end

endmodule

[rtl/kvma_checker.sv]
// Port-level checks for the keyframe vertex morph animator, bound to the top level.
// Depends on kvma_pkg and on the port list of keyframe_vertex_morph_animator.
module kvma_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [kvma_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import kvma_pkg::*;

    // A result waiting for the sink holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // A result never shows straight after its item is taken; the item passes the execute state first.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared one cycle after transfer");

    // The position never runs past the last frame.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[FPOS_W-1:0] <= POS_LIMIT)
        else $error("frame position out of range");

endmodule

bind keyframe_vertex_morph_animator kvma_checker u_kvma_checker (.*);
